@@ design/fba_pkg.sv @@
// Shared types and codes for the frame bitmap allocator.
// Holds the input and result payload structs, operation, status and register codes.
// No dependencies.
`default_nettype none

package fba_pkg;

  // Bitmap word width
  localparam int WORD_BITS = 32;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT  = 1'b1;

  // Operation codes
  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_MARK_FREE = 3'd2;
  localparam logic [2:0] OP_RESERVE   = 3'd3;
  localparam logic [2:0] OP_MARK_ALL  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic [31:0] length;
  } fba_in_t;

  typedef struct packed {
    logic [31:0] frame_address;
    logic [1:0]  status;
  } fba_out_t;

endpackage

`default_nettype wire

@@ design/fba_map_ram.sv @@
// Used/free bitmap storage: one write port, one read port, registered read data.
// Standalone; no package dependency.
`default_nettype none

module fba_map_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/frame_bitmap_allocator_unit.sv @@
// Frame allocator: allocate is a first-fit scan (one bitmap word scanned per cycle);
// free clears one frame bit; region ops read-modify-write the words touched (one per cycle);
// mark-all-used sets every word to all used (one word written per cycle). One item at a time.
// Reset: config registers clear, then a fill pass sets every bitmap word to all used; no input
// is taken until it ends. FRAME_BYTES must be a power of two; the block does not check it.
`default_nettype none

module frame_bitmap_allocator_unit
  import fba_pkg::*;
#(
  parameter int MAX_FRAMES  = 65536,
  parameter int FRAME_BYTES = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire fba_in_t                in_item,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output fba_out_t                    out_item,
  // configuration writes
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FIW  = AW + 5;                       // frame index
  localparam int NW   = $clog2(MAX_FRAMES + 1);       // frame count
  localparam int FS   = $clog2(FRAME_BYTES);          // frame offset bits
  localparam int UW   = 34 - FS;                      // region ends in frame units
  localparam int CW   = (UW > NW) ? UW : NW;          // compare width
  localparam int KW   = (NW > 17) ? NW : 17;          // count clamp width
  localparam int BFW  = 32 - FS;                      // base in frame units
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  // Control state
  logic [2:0]     state;
  logic           sweep_reply;
  logic           issuing;
  logic           rd_pend;
  // Configuration
  logic [31:0]    base_address;
  logic [16:0]    frame_count;
  // Item and work registers
  logic [2:0]     op_r;
  logic [31:0]    addr_r;
  logic [31:0]    len_r;
  logic [UW-1:0]  ua;
  logic [UW-1:0]  ue;
  logic [FIW-1:0] fa;
  logic [FIW-1:0] fl;
  logic [AW-1:0]  w_cur;
  logic [AW-1:0]  w_last;
  logic [AW-1:0]  rd_w;
  logic [31:0]    rd_mask;
  logic           set_mode;
  logic [1:0]     status_r;
  logic [FIW-1:0] found_f;

  // Memory port
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [31:0]    ram_wdata;
  logic [31:0]    ram_q;

  // Derived values
  logic [NW-1:0]  n;
  logic [KW-1:0]  fc_ext;
  logic [31:0]    base_al;
  logic [BFW-1:0] base_f;
  logic [32:0]    sum33;
  logic [31:0]    free_off;
  logic [BFW-1:0] free_f;
  logic [NW-1:0]  nm1;
  logic [CW-1:0]  first_c;
  logic [CW-1:0]  last_c;
  logic [CW-1:0]  clip_c;
  logic [FIW-1:0] first_f;
  logic [FIW-1:0] lastinc_f;
  logic [4:0]     lo_bit;
  logic [4:0]     hi_bit;
  logic [31:0]    walk_mask;
  logic [31:0]    valid_bits;
  logic [31:0]    free_bits;
  logic [31:0]    pick;
  logic [4:0]     pick_idx;
  logic           accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Managed frame count and aligned base
  assign fc_ext  = KW'(frame_count);
  assign n       = (fc_ext > KW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(fc_ext);
  assign base_al = {base_address[31:FS], {FS{1'b0}}};
  assign base_f  = base_address[31:FS];
  assign nm1     = n - NW'(1);

  // Single-frame free
  assign free_off = addr_r - base_al;
  assign free_f   = free_off[31:FS];

  // Region ends
  assign sum33 = {1'b0, addr_r} + {1'b0, len_r};

  // Region range relative to base, clipped to the managed count
  assign first_c   = CW'(ua) - CW'(base_f);
  assign last_c    = CW'(ue) - CW'(base_f);
  assign clip_c    = (last_c > CW'(n)) ? CW'(n) : last_c;
  assign first_f   = FIW'(first_c);
  assign lastinc_f = FIW'(clip_c - CW'(1));

  // Bit mask for the word being issued in a region walk
  assign lo_bit    = (w_cur == fa[FIW-1:5]) ? fa[4:0] : 5'd0;
  assign hi_bit    = (w_cur == w_last) ? fl[4:0] : 5'd31;
  assign walk_mask = ({32{1'b1}} << lo_bit) & ({32{1'b1}} >> (~hi_bit));

  // Free bits of the returned word, limited to managed frames
  assign valid_bits = (rd_w == w_last) ? ({32{1'b1}} >> (~fl[4:0])) : {32{1'b1}};
  assign free_bits  = ~ram_q & valid_bits;
  assign pick       = free_bits & (~free_bits + 32'd1);

  // Lowest free bit index
  always_comb begin
    pick_idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (free_bits[i]) begin
        pick_idx = 5'(i);
      end
    end
  end

  // Bitmap write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_w;
    ram_wdata = ram_q;
    case (state)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = w_cur;
        ram_wdata = {32{1'b1}};
      end
      S_WALK: begin
        ram_we    = rd_pend;
        ram_wdata = set_mode ? (ram_q | rd_mask) : (ram_q & ~rd_mask);
      end
      S_SCAN: begin
        ram_we    = rd_pend && (free_bits != 32'd0);
        ram_wdata = ram_q | pick;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (w_cur),
    .rdata (ram_q)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      frame_count  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_FRAME_COUNT:  frame_count  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_item.operation;
      addr_r <= in_item.address;
      len_r  <= in_item.length;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_reply <= 1'b0;
      issuing     <= 1'b0;
      rd_pend     <= 1'b0;
      w_cur       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            if (in_item.operation == OP_MARK_ALL) begin
              state       <= S_SWEEP;
              sweep_reply <= 1'b1;
              w_cur       <= '0;
            end else begin
              state <= S_PREP;
            end
          end
        end

        // Fill every word with ones (reset and mark-all-used)
        S_SWEEP: begin
          if (w_cur == LAST_WORD) begin
            w_cur <= '0;
            if (sweep_reply) begin
              status_r <= ST_DONE;
              state    <= S_FINISH;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            w_cur <= w_cur + AW'(1);
          end
        end

        // Decode and first range arithmetic
        S_PREP: begin
          status_r <= ST_IGNORED;
          state    <= S_FINISH;
          if (n != '0) begin
            case (op_r)
              OP_ALLOC: begin
                fl       <= FIW'(nm1);
                w_last   <= AW'(FIW'(nm1) >> 5);
                w_cur    <= '0;
                issuing  <= 1'b1;
                rd_pend  <= 1'b0;
                state    <= S_SCAN;
              end
              OP_FREE: begin
                if ((addr_r >= base_al) && (CW'(free_f) < CW'(n))) begin
                  fa       <= FIW'(free_f);
                  fl       <= FIW'(free_f);
                  w_cur    <= AW'(FIW'(free_f) >> 5);
                  w_last   <= AW'(FIW'(free_f) >> 5);
                  set_mode <= 1'b0;
                  issuing  <= 1'b1;
                  rd_pend  <= 1'b0;
                  state    <= S_WALK;
                end
              end
              OP_MARK_FREE: begin
                ua       <= UW'(addr_r >> FS) + UW'(|addr_r[FS-1:0]);
                ue       <= UW'(sum33 >> FS);
                set_mode <= 1'b0;
                if (len_r != '0) begin
                  state <= S_CHECK;
                end
              end
              OP_RESERVE: begin
                ua       <= UW'(addr_r >> FS);
                ue       <= UW'(sum33 >> FS) + UW'(|sum33[FS-1:0]);
                set_mode <= 1'b1;
                if (len_r != '0) begin
                  state <= S_CHECK;
                end
              end
              default: ;
            endcase
          end
        end

        // Range checks against base and count
        S_CHECK: begin
          if ((ue <= ua) || (ua < UW'(base_f)) || (first_c >= CW'(n))) begin
            status_r <= ST_IGNORED;
            state    <= S_FINISH;
          end else begin
            fa      <= first_f;
            fl      <= lastinc_f;
            w_cur   <= first_f[FIW-1:5];
            w_last  <= lastinc_f[FIW-1:5];
            issuing <= 1'b1;
            rd_pend <= 1'b0;
            state   <= S_WALK;
          end
        end

        // Read-modify-write over the words of the range, one per cycle
        S_WALK: begin
          rd_pend <= issuing;
          if (issuing) begin
            rd_w    <= w_cur;
            rd_mask <= walk_mask;
            if (w_cur == w_last) begin
              issuing <= 1'b0;
            end else begin
              w_cur <= w_cur + AW'(1);
            end
          end
          if (!issuing && rd_pend) begin
            status_r <= ST_DONE;
            state    <= S_FINISH;
          end
        end

        // First-fit scan, one word per cycle
        S_SCAN: begin
          rd_pend <= issuing;
          if (issuing) begin
            rd_w <= w_cur;
            if (w_cur == w_last) begin
              issuing <= 1'b0;
            end else begin
              w_cur <= w_cur + AW'(1);
            end
          end
          if (rd_pend) begin
            if (free_bits != 32'd0) begin
              found_f  <= {rd_w, pick_idx};
              status_r <= ST_DONE;
              issuing  <= 1'b0;
              state    <= S_FINISH;
            end else if (!issuing) begin
              status_r <= ST_NONE;
              state    <= S_FINISH;
            end
          end
        end

        // Hand the result to the output register
        S_FINISH: begin
          rd_pend <= 1'b0;
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!out_valid || out_ready)) begin
      out_item.status <= status_r;
      if ((op_r == OP_ALLOC) && (status_r == ST_DONE)) begin
        out_item.frame_address <= base_al + (32'(found_f) << FS);
      end else begin
        out_item.frame_address <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ test/frame_bitmap_allocator_unit_test.sv @@
// Testbench for frame_bitmap_allocator_unit: allocate, free, region, mark-all and spare-code
// requests under several base/count settings, each result checked against a bitmap model
// kept in this module. Depends on fba_pkg and the frame_bitmap_allocator_unit RTL.
module frame_bitmap_allocator_unit_test;
  import fba_pkg::*;

  localparam int MAX_FRAMES  = 65536;
  localparam int FRAME_BYTES = 4096;
  localparam int MAP_WORDS   = MAX_FRAMES / WORD_BITS;
  localparam longint RUN_LIMIT = 200_000_000;
  // codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fba_in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fba_out_t out_item;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model copy of the bitmap and registers
  logic [WORD_BITS-1:0] frame_used [MAP_WORDS];
  logic [31:0] base_setting;
  logic [16:0] count_setting;

  fba_in_t queued_requests [$];
  fba_out_t awaited_outcomes [$];
  bit steady_flow = 1'b0;
  int error_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int status_tally [4];

  always #5 clk = ~clk;

  frame_bitmap_allocator_unit #(
    .MAX_FRAMES (MAX_FRAMES),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------- bitmap model

  function automatic logic [63:0] managed_frames();
    return (count_setting < MAX_FRAMES) ? 64'(count_setting) : 64'(MAX_FRAMES);
  endfunction

  function automatic logic [63:0] aligned_base();
    return 64'(base_setting) / FRAME_BYTES * FRAME_BYTES;
  endfunction

  function automatic void mark_frame(logic [63:0] frame, logic used);
    frame_used[frame / WORD_BITS][frame % WORD_BITS] = used;
  endfunction

  // Region walk over [start, stop) in bytes, clipped to the managed frames
  function automatic logic [1:0] apply_span(logic [63:0] start, logic [63:0] stop,
                                            logic used);
    logic [63:0] n, b, first, last_ex, f;
    n = managed_frames();
    b = aligned_base();
    if (start < b) return ST_IGNORED;
    first = (start - b) / FRAME_BYTES;
    if (first >= n) return ST_IGNORED;
    last_ex = (stop - b) / FRAME_BYTES;
    if (last_ex > n) last_ex = n;
    for (f = first; f < last_ex; f++) mark_frame(f, used);
    return ST_DONE;
  endfunction

  // Applies one request to the model and returns the result it should produce
  function automatic fba_out_t allocator_outcome(fba_in_t req);
    fba_out_t res;
    logic [63:0] n, b, fb, addr, len, start, stop, words, f;
    logic [WORD_BITS-1:0] free_bits;
    int w, k;
    n = managed_frames();
    b = aligned_base();
    fb = FRAME_BYTES;
    addr = req.address;
    len = req.length;
    res.frame_address = '0;
    res.status = ST_IGNORED;
    if (req.operation == OP_MARK_ALL) begin
      foreach (frame_used[i]) frame_used[i] = '1;
      res.status = ST_DONE;
    end else if (n != 0) begin
      case (req.operation)
        OP_ALLOC: begin
          // first fit: lowest free managed frame
          res.status = ST_NONE;
          words = (n + WORD_BITS - 1) / WORD_BITS;
          for (w = 0; w < words && res.status == ST_NONE; w++) begin
            free_bits = ~frame_used[w];
            if ((w + 1) * WORD_BITS > n) free_bits &= (32'h1 << (n - w * WORD_BITS)) - 1;
            for (k = 0; k < WORD_BITS && res.status == ST_NONE; k++) begin
              if (free_bits[k]) begin
                f = w * WORD_BITS + k;
                mark_frame(f, 1'b1);
                res.frame_address = 32'(b + f * fb);
                res.status = ST_DONE;
              end
            end
          end
        end
        OP_FREE: begin
          if (addr >= b && addr < b + n * fb) begin
            mark_frame((addr - b) / fb, 1'b0);
            res.status = ST_DONE;
          end
        end
        OP_MARK_FREE: begin
          // round inward: only whole frames come free
          start = (addr + fb - 1) / fb * fb;
          stop = (addr + len) / fb * fb;
          if (len != 0 && stop > start) res.status = apply_span(start, stop, 1'b0);
        end
        OP_RESERVE: begin
          // round outward: every touched frame is taken
          start = addr / fb * fb;
          stop = (addr + len + fb - 1) / fb * fb;
          if (len != 0) res.status = apply_span(start, stop, 1'b1);
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic void queue_request(logic [2:0] op, logic [31:0] addr, logic [31:0] len);
    fba_in_t req;
    req.operation = op;
    req.address = addr;
    req.length = len;
    queued_requests.push_back(req);
  endfunction

  // Random request shaped around the current base and count
  function automatic fba_in_t draw_request();
    fba_in_t req;
    logic [63:0] n, b, spot;
    int unsigned roll;
    n = managed_frames();
    b = aligned_base();
    roll = $urandom_range(99);
    req.address = $urandom;
    req.length = $urandom;
    if (roll < 36) req.operation = OP_ALLOC;
    else if (roll < 60) req.operation = OP_FREE;
    else if (roll < 74) req.operation = OP_MARK_FREE;
    else if (roll < 89) req.operation = OP_RESERVE;
    else if (roll < 92) req.operation = OP_MARK_ALL;
    else if (roll < 96) req.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else req.operation = 3'($urandom_range(OP_ALLOC, OP_RESERVE));
    // most requests aim at the managed window; the rest keep raw random fields
    if (roll < 96 && $urandom_range(9) != 0) begin
      case ($urandom_range(5))
        0: spot = b - $urandom_range(1, 3 * FRAME_BYTES);
        1, 2: spot = b + 64'($urandom_range(0, 32'(n < 70 ? n + 1 : 70))) * FRAME_BYTES;
        default: spot = b + 64'($urandom_range(0, 32'(n) + 1)) * FRAME_BYTES;
      endcase
      if ($urandom_range(1)) spot += $urandom_range(FRAME_BYTES - 1);
      req.address = spot[31:0];
      case ($urandom_range(9))
        0: req.length = '0;
        1: req.length = $urandom_range(1, FRAME_BYTES - 1);
        2: req.length = $urandom_range(1, 32'(n) + 4) * FRAME_BYTES;
        default: req.length = $urandom_range(1, 24) * FRAME_BYTES
                              + ($urandom_range(1) ? $urandom_range(FRAME_BYTES - 1) : 0);
      endcase
    end
    return req;
  endfunction

  function automatic void add_random(int count);
    repeat (count) queued_requests.push_back(draw_request());
  endfunction

  function automatic bit take_break();
    return !steady_flow && ($urandom_range(99) < 22);
  endfunction

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    if (index == REG_BASE_ADDRESS) base_setting = value;
    else count_setting = value[16:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [31:0] base, logic [16:0] count);
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_FRAME_COUNT, CFG_DATA_W'(count));
    settings_used++;
  endtask

  // Waits until every queued request is taken and every result is back or the wait runs out
  task automatic drain();
    int waited;
    waited = 0;
    while (queued_requests.size() != 0 || in_valid) @(negedge clk);
    while (awaited_outcomes.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_outcomes.size() != 0) begin
      error_count += awaited_outcomes.size();
      $display("%0d results never arrived", awaited_outcomes.size());
      awaited_outcomes.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- request driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_outcomes.push_back(allocator_outcome(in_item));
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (queued_requests.size() != 0 && !take_break()) begin
          in_item  <= queued_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk) begin : result_monitor
    fba_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("result %0d with nothing outstanding: address %h status %0d",
                     results_seen, out_item.frame_address, out_item.status);
        end else begin
          want = awaited_outcomes.pop_front();
          status_tally[want.status]++;
          if (out_item.frame_address !== want.frame_address ||
              out_item.status !== want.status) begin
            error_count++;
            if (error_count <= 10)
              $display("result %0d: expected address %h status %0d, got address %h status %0d",
                       results_seen, want.frame_address, want.status,
                       out_item.frame_address, out_item.status);
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : stimulus
    logic [31:0] b;
    foreach (frame_used[i]) frame_used[i] = '1;
    base_setting = '0;
    count_setting = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: allocator not initialized
    queue_request(OP_ALLOC, '0, '0);
    queue_request(OP_FREE, '0, '0);
    queue_request(OP_MARK_FREE, '0, 32'hFFFF_FFFF);
    queue_request(OP_RESERVE, '0, FRAME_BYTES);
    queue_request(OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_SPARE_LO + 3'd1, '0, '0);
    queue_request(OP_SPARE_HI, '0, '0);
    queue_request(OP_MARK_ALL, '0, '0);
    drain();

    // small window, unaligned base register
    configure(32'h0010_0123, 17'd64);
    b = 32'(aligned_base());
    queue_request(OP_ALLOC, '0, '0);                                 // all used
    queue_request(OP_MARK_FREE, b + 32'h800, 10 * FRAME_BYTES);      // inward rounding
    queue_request(OP_ALLOC, '0, '0);
    queue_request(OP_FREE, b + 32'hFFF, '0);
    queue_request(OP_ALLOC, '0, '0);
    queue_request(OP_FREE, b - 1, '0);                               // below base
    queue_request(OP_FREE, b + 64 * FRAME_BYTES, '0);                // one past end
    queue_request(OP_MARK_FREE, b + 32'h10, FRAME_BYTES);            // no whole frame
    queue_request(OP_RESERVE, b + 2 * FRAME_BYTES + 5, '0);          // zero length
    queue_request(OP_RESERVE, b + 2 * FRAME_BYTES + 5, FRAME_BYTES); // outward rounding
    queue_request(OP_MARK_FREE, b - FRAME_BYTES, 4 * FRAME_BYTES);   // start below base
    queue_request(OP_RESERVE, b + 64 * FRAME_BYTES, 1);              // start past end
    queue_request(OP_MARK_FREE, b + 60 * FRAME_BYTES, 32'hFFFF_FFFF); // clipped at end
    queue_request(OP_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);         // end beyond 32 bits
    queue_request(OP_MARK_ALL, '0, '0);
    add_random(250);
    drain();

    configure(32'h0000_0000, 17'd1);
    add_random(60);
    drain();

    // top of the address space, full count: allocated addresses wrap
    configure(32'hFFFF_FFFF, 17'd65536);
    queue_request(OP_MARK_FREE, 32'hFFFF_F000, 32'hFFFF_FFFF);
    queue_request(OP_ALLOC, '0, '0);
    queue_request(OP_ALLOC, '0, '0);
    queue_request(OP_RESERVE, 32'hFFFF_F800, 32'h100);
    add_random(80);
    drain();

    // count back to zero, then a larger count that sees the old bits
    configure(32'h0004_0000, 17'd0);
    add_random(20);
    drain();
    configure(32'h0004_0000, 17'd1000);
    steady_flow = 1'b1;
    add_random(200);
    drain();
    steady_flow = 1'b0;

    configure(32'h1234_5678, 17'd37);
    add_random(150);
    drain();

    configure(32'h0000_0000, 17'd65536);
    add_random(40);
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests under %0d base/count settings; %0d results checked.",
             requests_sent, settings_used, results_seen);
    $display("Outcomes: %0d done, %0d with no free frame, %0d ignored.",
             status_tally[ST_DONE], status_tally[ST_NONE], status_tally[ST_IGNORED]);
    if (error_count == 0) begin
      $display("frame_bitmap_allocator_unit test passed");
    end else begin
      $display("frame_bitmap_allocator_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("frame_bitmap_allocator_unit test failed");
    $finish;
  end

endmodule
